[src/sliding_window_maximum_defines.svh]
// Assertion macros for the sliding window maximum RTL.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/swm_pkg.sv]
// Package with constants and types for the sliding window maximum block.
package swm_pkg;

    // Longest supported window and sample width
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // Width of a fill count that can hold WINDOW_MAX itself
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    // Width of a cell index
    localparam int IDX_W = $clog2(WINDOW_MAX);

    // Configuration register map (word index = paddr[2])
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam int   PADDR_W         = 3;
    localparam int   PDATA_W         = 32;
    localparam int   WSIZE_W         = 7;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

endpackage

[src/swm_cell.sv]
// One cell of the max chain: holds the maximum of the newest (index+1) samples.
module swm_cell (
    input  logic              clk,
    input  logic              load,
    input  swm_pkg::sample_t  sample,
    input  swm_pkg::sample_t  prev_max,
    output swm_pkg::sample_t  cell_max
);

    swm_pkg::sample_t max_reg;
    swm_pkg::sample_t max_next;

    // Fold the new sample into what the neighbor currently holds
    always_comb
    begin
        max_next = (sample > prev_max) ? sample : prev_max;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            max_reg <= max_next;
        end
    end

    assign cell_max = max_reg;

endmodule

[src/swm_sel.sv]
// Picks the chain tap for the current window and folds in the arriving sample.
module swm_sel (
    input  swm_pkg::sample_t                 taps [swm_pkg::WINDOW_MAX],
    input  logic                             use_tap,
    input  logic [swm_pkg::IDX_W-1:0]        tap_idx,
    input  swm_pkg::sample_t                 sample,
    output swm_pkg::sample_t                 best
);

    logic [swm_pkg::SAMPLE_WIDTH-1:0] tap_or;
    swm_pkg::sample_t                 tap_val;

    // One-hot AND-OR select over the cells
    always_comb
    begin
        tap_or = '0;
        for (int j = 0; j < swm_pkg::WINDOW_MAX; j++)
        begin
            if (tap_idx == swm_pkg::IDX_W'(j))
            begin
                tap_or = tap_or | taps[j];
            end
        end
        tap_val = swm_pkg::sample_t'(tap_or);
    end

    // Larger of tap and sample; a window of one takes the sample alone
    always_comb
    begin
        if (use_tap && (tap_val > sample))
        begin
            best = tap_val;
        end
        else
        begin
            best = sample;
        end
    end

endmodule

[src/sliding_window_maximum.sv]
// Sliding window maximum: one transfer per cycle while not stalled.
// A result is written to the output register when its sample is accepted.
// One sample per cycle unless stalled; each of the 64 chain cells does one compare.
// Input stalls only while a result is held and m_tready is low.
// Reset (async, rst_n low): window_size = 1, fill count zero, no result held.
// Chain contents are not reset; a window only covers samples of its sequence.
module sliding_window_maximum (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swm_pkg::PADDR_W-1:0]   paddr,
    input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
    output logic [swm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // Sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] sample
    input  logic                          s_tlast,   // last_sample
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] window_max
    output logic                          m_tlast    // last_window
);

    `include "sliding_window_maximum_defines.svh"

    logic [swm_pkg::WSIZE_W-1:0] window_size_reg;
    logic [swm_pkg::CNT_W-1:0]   fill_count_reg;
    logic [swm_pkg::CNT_W-1:0]   fill_count_next;
    logic                        out_valid_reg;
    swm_pkg::sample_t            out_max_reg;
    logic                        out_last_reg;

    logic                        cfg_write;
    logic                        in_accept;
    logic                        produce;
    logic [swm_pkg::CNT_W-1:0]   win_len;
    logic [swm_pkg::CNT_W-1:0]   fill_inc;
    logic                        use_tap;
    logic [swm_pkg::IDX_W-1:0]   tap_idx;
    swm_pkg::sample_t            sample;
    swm_pkg::sample_t            best;
    swm_pkg::sample_t            chain [swm_pkg::WINDOW_MAX];

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WSIZE_W'(1);
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[swm_pkg::WSIZE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == swm_pkg::REG_WINDOW_SIZE)
        begin
            prdata = swm_pkg::PDATA_W'(window_size_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Effective window: zero acts as one, large values clamp
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_len = swm_pkg::CNT_W'(1);
        end
        else if (window_size_reg > swm_pkg::WSIZE_W'(swm_pkg::WINDOW_MAX))
        begin
            win_len = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            win_len = swm_pkg::CNT_W'(window_size_reg);
        end
        use_tap = (win_len > swm_pkg::CNT_W'(1));
        tap_idx = swm_pkg::IDX_W'(win_len - swm_pkg::CNT_W'(2));
    end

    // Handshake and fill count
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign sample    = swm_pkg::sample_t'(s_tdata);

    always_comb
    begin
        if (fill_count_reg == swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX))
        begin
            fill_inc = fill_count_reg;
        end
        else
        begin
            fill_inc = fill_count_reg + swm_pkg::CNT_W'(1);
        end
        produce         = (fill_inc >= win_len);
        fill_count_next = s_tlast ? '0 : fill_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (in_accept)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // Chain of cells: cell j holds the max of the newest j+1 samples
    genvar g;
    generate
        for (g = 0; g < swm_pkg::WINDOW_MAX; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                swm_cell u_cell (
                    .clk      (clk),
                    .load     (in_accept),
                    .sample   (sample),
                    .prev_max (sample),
                    .cell_max (chain[g])
                );
            end
            else
            begin : g_body
                swm_cell u_cell (
                    .clk      (clk),
                    .load     (in_accept),
                    .sample   (sample),
                    .prev_max (chain[g-1]),
                    .cell_max (chain[g])
                );
            end
        end
    endgenerate

    // Window result from the chain as it stood before this sample
    swm_sel u_sel (
        .taps    (chain),
        .use_tap (use_tap),
        .tap_idx (tap_idx),
        .sample  (sample),
        .best    (best)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && produce)
        begin
            out_max_reg  <= best;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_max_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `SWM_ASSERT_IMP(a_fill_bound, 1'b1,
        fill_count_reg <= swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX),
        "fill count beyond window capacity")
    `SWM_ASSERT_NXT(a_last_clears, in_accept && s_tlast, fill_count_reg == '0,
        "sequence state not cleared after last sample")
    `SWM_ASSERT_IMP(a_result_cause, $rose(out_valid_reg), $past(in_accept && produce),
        "result appeared without a producing sample")
    `SWM_ASSERT_NXT(a_no_drop, out_valid_reg && !m_tready, out_valid_reg,
        "held result lost while stalled")

endmodule

[verif/tb_sliding_window_maximum.sv]
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module tb_sliding_window_maximum;

    // Register addresses and run limits
    localparam logic [swm_pkg::PADDR_W-1:0] ADDR_WINDOW_SIZE =
        {swm_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam logic [swm_pkg::PADDR_W-1:0] ADDR_UNMAPPED    =
        {~swm_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 950;
    localparam int PRINT_CAP     = 40;

    typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_FALLING, PAT_RISING, PAT_NEAR_ZERO}
        sample_pattern_t;

    typedef struct {
        swm_pkg::sample_t smp;
        bit               lst;
    } sample_item_t;

    typedef struct {
        swm_pkg::sample_t wmax;
        bit               wlast;
    } window_result_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [swm_pkg::PADDR_W-1:0]  paddr    = '0;
    logic [swm_pkg::PDATA_W-1:0]  pwdata   = '0;
    logic [swm_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata  = '0;   // [31:0] sample
    logic                         s_tlast  = 1'b0; // last_sample
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [31:0]                  m_tdata;         // [31:0] window_max
    logic                         m_tlast;         // last_window

    // Stimulus and scoreboard storage
    sample_item_t   sample_q[$];
    window_result_t pending_max_q[$];
    int             err_cnt      = 0;
    int             total_queued = 0;
    int             gap_left     = 0;
    int             stall_left   = 0;
    int             quiet_cycles = 0;
    bit             src_busy     = 1'b1;
    bit             sink_busy    = 1'b1;
    sample_item_t   next_item;
    window_result_t want;

    // Shadow state of the block
    swm_pkg::sample_t             hist[swm_pkg::WINDOW_MAX];
    int                           fill_cnt = 0;
    int                           wr_pos   = 0;
    logic [swm_pkg::WSIZE_W-1:0]  win_size = 7'd1;

    sliding_window_maximum uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Window size 0 acts as 1, anything above the store depth saturates
    function automatic int effective_span(input logic [swm_pkg::WSIZE_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > swm_pkg::WINDOW_MAX)
            return swm_pkg::WINDOW_MAX;
        return w;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int draw_gap(input bit busy);
        int r;
        if (!busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Update the shadow window with one accepted sample and queue its maximum
    task automatic predict_window_max(input swm_pkg::sample_t smp, input bit lst);
        int               span;
        int               newest;
        int               i;
        swm_pkg::sample_t best;
        window_result_t   res;
        span = effective_span(win_size);
        newest = wr_pos;
        hist[newest] = smp;
        wr_pos = (newest + 1) % swm_pkg::WINDOW_MAX;
        if (fill_cnt < swm_pkg::WINDOW_MAX)
            fill_cnt++;
        if (fill_cnt >= span)
        begin
            best = smp;
            for (i = 1; i < span; i++)
            begin
                if (hist[(newest + swm_pkg::WINDOW_MAX - i) % swm_pkg::WINDOW_MAX] > best)
                    best = hist[(newest + swm_pkg::WINDOW_MAX - i) % swm_pkg::WINDOW_MAX];
            end
            res.wmax  = best;
            res.wlast = lst;
            pending_max_q.insert(pending_max_q.size(), res);
        end
        if (lst)
        begin
            fill_cnt = 0;
            wr_pos = 0;
        end
    endtask

    // Sample stream driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_window_max(s_tdata, s_tlast);
            if (s_tvalid && !s_tready)
            begin
                // hold the current transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                next_item = sample_q.pop_front();
                s_tdata  <= next_item.smp;
                s_tlast  <= next_item.lst;
                s_tvalid <= 1'b1;
                gap_left = draw_gap(src_busy);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_max_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result max=%h last=%b",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    want = pending_max_q.pop_front();
                    if (m_tdata !== want.wmax)
                        report_mismatch($sformatf("window_max got %h want %h",
                                                  m_tdata, want.wmax));
                    if (m_tlast !== want.wlast)
                        report_mismatch($sformatf("last_window got %b want %b",
                                                  m_tlast, want.wlast));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = draw_gap(sink_busy);
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_write(input logic [swm_pkg::PADDR_W-1:0] addr,
                             input logic [swm_pkg::PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WINDOW_SIZE)
            win_size = data[swm_pkg::WSIZE_W-1:0];
    endtask

    // Read window_size back and compare with the shadow copy
    task automatic apb_read_check();
        logic [swm_pkg::PDATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== swm_pkg::PDATA_W'(win_size))
            report_mismatch($sformatf("window_size read %h want %h", got, win_size));
    endtask

    task automatic push_item(input swm_pkg::sample_t smp, input bit lst);
        sample_item_t it;
        it.smp = smp;
        it.lst = lst;
        sample_q.insert(sample_q.size(), it);
        total_queued++;
    endtask

    // Wait until every sample is sent and every expected result has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || pending_max_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic swm_pkg::sample_t next_sample(input sample_pattern_t pat,
                                                     input swm_pkg::sample_t prev);
        case (pat)
            PAT_EXTREME:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h8000_0001;
                    default: return 32'h0000_0001;
                endcase
            end
            PAT_FALLING:   return prev - $urandom_range(0, 1000);
            PAT_RISING:    return prev + $urandom_range(0, 1000);
            PAT_NEAR_ZERO: return $signed($urandom_range(0, 40)) - 20;
            default:       return $urandom;
        endcase
    endfunction

    task automatic queue_sequence(input int len, input bit closed);
        sample_pattern_t  pat;
        swm_pkg::sample_t smp;
        int               i;
        pat = sample_pattern_t'($urandom_range(0, 4));
        smp = $urandom;
        for (i = 0; i < len; i++)
        begin
            smp = next_sample(pat, smp);
            push_item(smp, closed && (i == len - 1));
        end
    endtask

    // One random phase: new window size, then a few sequences
    task automatic run_random_phase(input logic [swm_pkg::WSIZE_W-1:0] wsize);
        int span;
        int nseq;
        int len;
        int r;
        int i;
        apb_write(ADDR_WINDOW_SIZE, swm_pkg::PDATA_W'(wsize));
        apb_read_check();
        src_busy  = ($urandom_range(0, 3) != 0);
        sink_busy = ($urandom_range(0, 3) != 0);
        span = effective_span(wsize);
        nseq = $urandom_range(1, 4);
        for (i = 0; i < nseq; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                len = $urandom_range(1, span);
            else if (r < 22)
                len = $urandom_range(swm_pkg::WINDOW_MAX + 1, 140);
            else
                len = span + $urandom_range(0, 20);
            // an open final sequence carries over into the next window size
            queue_sequence(len, !(i == nseq - 1 && $urandom_range(0, 4) == 0));
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of one: extremes pass straight through
        apb_read_check();
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0001, 1'b1);
        wait_drained();

        // Window of three: a short sequence, then signed extremes
        apb_write(ADDR_WINDOW_SIZE, 32'd3);
        apb_read_check();
        push_item(-5, 1'b0);
        push_item(7, 1'b1);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h8000_0001, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // Window size zero behaves as one
        apb_write(ADDR_WINDOW_SIZE, 32'd0);
        apb_read_check();
        push_item(32'h1234_5678, 1'b0);
        push_item(32'hEDCB_A987, 1'b1);
        wait_drained();

        // Window shrinks in the middle of a sequence; unmapped write is dropped
        apb_write(ADDR_WINDOW_SIZE, 32'd4);
        push_item(10, 1'b0);
        push_item(20, 1'b0);
        push_item(30, 1'b0);
        wait_drained();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFE);
        apb_read_check();
        apb_write(ADDR_WINDOW_SIZE, 32'd2);
        push_item(5, 1'b0);
        push_item(1, 1'b1);
        wait_drained();

        // Random phases, extremes of the window size first
        phase = 0;
        while (total_queued < RANDOM_ITEMS)
        begin
            case (phase)
                0: run_random_phase(7'd64);
                1: run_random_phase(7'd127);
                2: run_random_phase(7'd65);
                3: run_random_phase(7'd1);
                4: run_random_phase(7'd0);
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        run_random_phase(swm_pkg::WSIZE_W'($urandom_range(0, 127)));
                    else
                        run_random_phase(swm_pkg::WSIZE_W'($urandom_range(1, 12)));
                end
            endcase
            phase++;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
